// ----- rtl/csps_pkg.sv -----
package csps_pkg;

	localparam int unsigned MaxLevelDefault = 255;
	localparam int unsigned CoordW = 24;
	localparam int unsigned CountW = 19;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 64;

	localparam logic [CfgIdxW-1:0] REG_GRID_LEVEL = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_BOX_SIZE = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_GRID_STEP = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_POSE_X = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_POSE_Y = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_POSE_Z = 3'd5;

	localparam logic [1:0] PH_SIDE = 2'd0;
	localparam logic [1:0] PH_BORDER = 2'd1;
	localparam logic [1:0] PH_CAP = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_out;
	} csps_cmd_t;

	// lattice position handed to the datapath
	typedef struct packed {
		logic [1:0] phase;
		logic       side;
		logic [9:0] layer;
		logic [9:0] line;
		logic [CountW-1:0] number;
		logic       last;
	} csps_pos_t;

endpackage

// ----- rtl/csps_ctrl.sv -----
module csps_ctrl #(
	parameter int unsigned MAX_LEVEL = csps_pkg::MaxLevelDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              grid_level,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    restart,
	input  logic                    out_stall,
	output logic                    out_valid,
	output csps_pkg::csps_cmd_t     cmd,
	output csps_pkg::csps_pos_t     pos
);

	localparam int unsigned LW = $clog2(MAX_LEVEL + 2);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_SUM = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	logic [1:0] state_q;
	logic [LW-1:0] layer_q, line_q, n;
	logic [1:0] phase_q;
	logic side_q;
	logic [csps_pkg::CountW-1:0] count_q;

	logic [LW-1:0] l0, k0, nl, nk;
	logic [1:0] p0, np;
	logic s0, ns, fits, last;

	always_comb begin
		if (grid_level == 8'd0) n = LW'(1);
		else if (32'(grid_level) > MAX_LEVEL) n = LW'(MAX_LEVEL);
		else n = LW'(grid_level);
	end

	always_comb begin
		unique case (phase_q)
			csps_pkg::PH_SIDE: fits = layer_q <= n && line_q <= n;
			csps_pkg::PH_BORDER: fits = layer_q <= n && line_q >= LW'(1) && line_q < n;
			csps_pkg::PH_CAP: fits = layer_q >= LW'(1) && layer_q < n &&
				line_q >= LW'(1) && line_q < n;
			default: fits = 1'b0;
		endcase
	end

	logic fresh;
	assign fresh = restart || !fits;
	assign k0 = fresh ? '0 : layer_q;
	assign l0 = fresh ? '0 : line_q;
	assign p0 = fresh ? csps_pkg::PH_SIDE : phase_q;
	assign s0 = fresh ? 1'b0 : side_q;

	// next position after the one emitted now
	always_comb begin
		nk = k0;
		nl = l0;
		np = p0;
		ns = 1'b0;
		last = 1'b0;
		if (!s0) begin
			ns = 1'b1;
		end else if (p0 == csps_pkg::PH_CAP) begin
			nl = l0 + LW'(1);
			if (nl >= n) begin
				nl = LW'(1);
				nk = k0 + LW'(1);
				if (nk >= n) last = 1'b1;
			end
		end else if (p0 == csps_pkg::PH_SIDE && l0 + LW'(1) <= n) begin
			nl = l0 + LW'(1);
		end else if (p0 == csps_pkg::PH_SIDE && n >= LW'(2)) begin
			np = csps_pkg::PH_BORDER;
			nl = LW'(1);
		end else if (p0 == csps_pkg::PH_BORDER && l0 + LW'(1) < n) begin
			nl = l0 + LW'(1);
		end else begin
			// next layer
			nl = '0;
			np = csps_pkg::PH_SIDE;
			nk = k0 + LW'(1);
			if (nk > n) begin
				if (n >= LW'(2)) begin
					np = csps_pkg::PH_CAP;
					nk = LW'(1);
					nl = LW'(1);
				end else begin
					last = 1'b1;
				end
			end
		end
		if (last) begin
			nk = '0;
			nl = '0;
			np = csps_pkg::PH_SIDE;
			ns = 1'b0;
		end
	end

	logic take;
	assign in_stall = state_q != ST_IDLE;
	assign take = in_valid && !in_stall;
	assign out_valid = state_q == ST_OUT;

	assign cmd.load_s1 = take;
	assign cmd.load_s2 = state_q == ST_MUL;
	assign cmd.load_out = state_q == ST_SUM;

	assign pos.phase = p0;
	assign pos.side = s0;
	assign pos.layer = 10'(k0);
	assign pos.line = 10'(l0);
	assign pos.number = fresh ? '0 : count_q;
	assign pos.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			layer_q <= '0;
			line_q <= '0;
			phase_q <= csps_pkg::PH_SIDE;
			side_q <= 1'b0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (take) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_OUT;
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (take) begin
				layer_q <= nk;
				line_q <= nl;
				phase_q <= np;
				side_q <= ns;
				count_q <= last ? '0 : pos.number + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/csps_dp.sv -----
module csps_dp (
	input  logic                    clk,
	input  logic [47:0]             box_size,
	input  logic [47:0]             grid_step,
	input  logic [63:0]             pose_row_x,
	input  logic [63:0]             pose_row_y,
	input  logic [63:0]             pose_row_z,
	input  csps_pkg::csps_cmd_t     cmd,
	input  csps_pkg::csps_pos_t     pos,
	output logic signed [23:0]      point_x,
	output logic signed [23:0]      point_y,
	output logic signed [23:0]      point_z,
	output logic [18:0]             point_number,
	output logic                    last_point
);

	logic [9:0] a_idx, b_idx;
	logic [15:0] a_step, b_step, face;
	logic [25:0] a_s1, b_s1;
	logic [15:0] face_s1;
	logic [1:0] phase_s1;
	logic [18:0] num_s1, num_s2;
	logic last_s1, last_s2;
	logic [25:0] x, y, z;

	// a is the line axis, b is the layer axis, face is the fixed coordinate
	always_comb begin
		a_idx = pos.line;
		b_idx = pos.layer;
		case (pos.phase)
			csps_pkg::PH_SIDE: begin
				a_step = grid_step[31:16];
				b_step = grid_step[47:32];
				face = pos.side ? box_size[15:0] : '0;
			end
			csps_pkg::PH_BORDER: begin
				a_step = grid_step[15:0];
				b_step = grid_step[47:32];
				face = pos.side ? box_size[31:16] : '0;
			end
			default: begin
				a_step = grid_step[31:16];
				b_step = grid_step[15:0];
				face = pos.side ? box_size[47:32] : '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_s1) begin
			a_s1 <= 26'(a_idx) * 26'(a_step);
			b_s1 <= 26'(b_idx) * 26'(b_step);
			face_s1 <= face;
			phase_s1 <= pos.phase;
			num_s1 <= pos.number;
			last_s1 <= pos.last;
		end
	end

	always_comb begin
		case (phase_s1)
			csps_pkg::PH_SIDE: begin
				x = 26'(face_s1); y = a_s1; z = b_s1;
			end
			csps_pkg::PH_BORDER: begin
				x = a_s1; y = 26'(face_s1); z = b_s1;
			end
			default: begin
				x = b_s1; y = a_s1; z = 26'(face_s1);
			end
		endcase
	end

	logic signed [42:0] px_s2 [3], py_s2 [3], pz_s2 [3];

	function automatic logic signed [42:0] mul(input logic [15:0] c, input logic [25:0] v);
		mul = 43'($signed(c)) * $signed({17'd0, v});
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load_s2) begin
			px_s2[0] <= mul(pose_row_x[63:48], x);
			px_s2[1] <= mul(pose_row_x[47:32], y);
			px_s2[2] <= mul(pose_row_x[31:16], z);
			py_s2[0] <= mul(pose_row_y[63:48], x);
			py_s2[1] <= mul(pose_row_y[47:32], y);
			py_s2[2] <= mul(pose_row_y[31:16], z);
			pz_s2[0] <= mul(pose_row_z[63:48], x);
			pz_s2[1] <= mul(pose_row_z[47:32], y);
			pz_s2[2] <= mul(pose_row_z[31:16], z);
			num_s2 <= num_s1;
			last_s2 <= last_s1;
		end
	end

	function automatic logic [23:0] finish(input logic signed [42:0] p0,
			input logic signed [42:0] p1, input logic signed [42:0] p2,
			input logic [15:0] t);
		logic signed [44:0] acc;
		logic signed [30:0] q;
		acc = 45'(p0) + 45'(p1) + 45'(p2) + 45'sd8192;
		// arithmetic shift floors, which is the round half up
		q = 31'(acc >>> 14) + 31'($signed(t));
		if (q > 31'sd8388607) finish = 24'h7FFFFF;
		else if (q < -31'sd8388608) finish = 24'h800000;
		else finish = q[23:0];
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			point_x <= finish(px_s2[0], px_s2[1], px_s2[2], pose_row_x[15:0]);
			point_y <= finish(py_s2[0], py_s2[1], py_s2[2], pose_row_y[15:0]);
			point_z <= finish(pz_s2[0], pz_s2[1], pz_s2[2], pose_row_z[15:0]);
			point_number <= num_s2;
			last_point <= last_s2;
		end
	end

endmodule

// ----- rtl/cuboid_surface_point_sampler_top.sv -----
// Box surface lattice sampler. Each accepted item (restart=1 starts over) returns the next of
// 6*L*L+2 surface lattice points, posed by three fixed-point affine rows and saturated to
// signed Q16.8. The lattice products are registered at the accepting edge, then the nine pose
// products in state MUL and the rounded, clamped result in state SUM; the result is then
// valid in state OUT. The next item is taken in the cycle after the result is taken, so a new
// item is not accepted until the last result has been taken, and later with a stalled output.
// Write configuration only while idle.
module cuboid_surface_point_sampler_top #(
	parameter int unsigned MAX_LEVEL = csps_pkg::MaxLevelDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    restart,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [23:0]      point_x,
	output logic signed [23:0]      point_y,
	output logic signed [23:0]      point_z,
	output logic [18:0]             point_number,
	output logic                    last_point,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [csps_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [csps_pkg::CfgDataW-1:0] cfg_data
);

	logic [7:0] grid_level_q;
	logic [47:0] box_size_q, grid_step_q;
	logic [63:0] pose_x_q, pose_y_q, pose_z_q;
	csps_pkg::csps_cmd_t cmd;
	csps_pkg::csps_pos_t pos;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_level_q <= 8'd1;
			box_size_q <= '0;
			grid_step_q <= '0;
			pose_x_q <= 64'h4000_0000_0000_0000;
			pose_y_q <= 64'h0000_4000_0000_0000;
			pose_z_q <= 64'h0000_0000_4000_0000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				csps_pkg::REG_GRID_LEVEL: grid_level_q <= cfg_data[7:0];
				csps_pkg::REG_BOX_SIZE: box_size_q <= cfg_data[47:0];
				csps_pkg::REG_GRID_STEP: grid_step_q <= cfg_data[47:0];
				csps_pkg::REG_POSE_X: pose_x_q <= cfg_data;
				csps_pkg::REG_POSE_Y: pose_y_q <= cfg_data;
				csps_pkg::REG_POSE_Z: pose_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	csps_ctrl #(.MAX_LEVEL(MAX_LEVEL)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .grid_level(grid_level_q),
		.in_valid(in_valid), .in_stall(in_stall), .restart(restart),
		.out_stall(out_stall), .out_valid(out_valid), .cmd(cmd), .pos(pos)
	);

	csps_dp u_dp (
		.clk(clk), .box_size(box_size_q), .grid_step(grid_step_q),
		.pose_row_x(pose_x_q), .pose_row_y(pose_y_q), .pose_row_z(pose_z_q),
		.cmd(cmd), .pos(pos), .point_x(point_x), .point_y(point_y),
		.point_z(point_z), .point_number(point_number), .last_point(last_point)
	);

endmodule
